// ----- hw/rtl/tfm_pkg.sv -----
package tfm_pkg;

  localparam int TEMP_W         = 16;
  localparam int DET_FIELDS     = 4;
  localparam int DET_COUNT_DEF  = 4;
  localparam int EXT_W          = 18;
  localparam int CFG_IDX_W      = 3;

  localparam int IN_TDATA_W     = TEMP_W * (DET_FIELDS + 1);
  localparam int IN_TUSER_W     = 1;
  localparam int OUT_TDATA_W    = 2 * TEMP_W;
  localparam int OUT_TUSER_W    = 5;

  localparam logic signed [TEMP_W-1:0] INVALID_TEMP = -16'sd10000;
  localparam logic signed [EXT_W-1:0]  RANGE_LO     = -18'sd400;
  localparam logic signed [EXT_W-1:0]  RANGE_HI     = 18'sd1200;
  localparam logic signed [EXT_W-1:0]  MAX_SPREAD   = 18'sd50;
  localparam logic signed [EXT_W-1:0]  HYST         = 18'sd20;

  localparam logic signed [TEMP_W-1:0] NONE_MAX     = -16'sd401;
  localparam logic signed [TEMP_W-1:0] NONE_MIN     = 16'sd1201;

  localparam logic [CFG_IDX_W-1:0] CFG_L3_SET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_L3_HEAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_SET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_HEAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_SET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_HEAL = 3'd5;

  localparam logic signed [TEMP_W-1:0] L3_SET_RST  = 16'sd1000;
  localparam logic signed [TEMP_W-1:0] L3_HEAL_RST = 16'sd950;
  localparam logic signed [TEMP_W-1:0] L2_SET_RST  = 16'sd900;
  localparam logic signed [TEMP_W-1:0] L2_HEAL_RST = 16'sd850;
  localparam logic signed [TEMP_W-1:0] L1_SET_RST  = 16'sd800;
  localparam logic signed [TEMP_W-1:0] L1_HEAL_RST = 16'sd750;

  typedef struct packed {
    logic signed [TEMP_W-1:0] l3_set;
    logic signed [TEMP_W-1:0] l3_heal;
    logic signed [TEMP_W-1:0] l2_set;
    logic signed [TEMP_W-1:0] l2_heal;
    logic signed [TEMP_W-1:0] l1_set;
    logic signed [TEMP_W-1:0] l1_heal;
  } tfm_thresh_t;

  typedef struct packed {
    logic level1;
    logic level2;
    logic level3;
    logic inhibit;
  } tfm_levels_t;

endpackage

// ----- hw/rtl/tfm_cfg_regs.sv -----
module tfm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tfm_pkg::TEMP_W-1:0]      cfg_wdata,
  output tfm_pkg::tfm_thresh_t            thresh
);
  import tfm_pkg::*;

  tfm_thresh_t thresh_r;
  tfm_thresh_t thresh_nxt;

  always_comb begin
    thresh_nxt = thresh_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_L3_SET:  thresh_nxt.l3_set  = cfg_wdata;
        CFG_L3_HEAL: thresh_nxt.l3_heal = cfg_wdata;
        CFG_L2_SET:  thresh_nxt.l2_set  = cfg_wdata;
        CFG_L2_HEAL: thresh_nxt.l2_heal = cfg_wdata;
        CFG_L1_SET:  thresh_nxt.l1_set  = cfg_wdata;
        CFG_L1_HEAL: thresh_nxt.l1_heal = cfg_wdata;
        default:     thresh_nxt = thresh_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.l3_set  <= L3_SET_RST;
      thresh_r.l3_heal <= L3_HEAL_RST;
      thresh_r.l2_set  <= L2_SET_RST;
      thresh_r.l2_heal <= L2_HEAL_RST;
      thresh_r.l1_set  <= L1_SET_RST;
      thresh_r.l1_heal <= L1_HEAL_RST;
    end else begin
      thresh_r <= thresh_nxt;
    end
  end

  assign thresh = thresh_r;

endmodule

// ----- hw/rtl/tfm_det_eval.sv -----
module tfm_det_eval #(
  parameter int DETECTOR_COUNT = tfm_pkg::DET_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic signed [tfm_pkg::TEMP_W-1:0] det_temp [tfm_pkg::DET_FIELDS],
  output logic                              det_fault,
  output logic signed [tfm_pkg::TEMP_W-1:0] det_max,
  output logic signed [tfm_pkg::TEMP_W-1:0] det_min
);
  import tfm_pkg::*;

  // out-of-range counts are clamped to the fields present
  localparam int DET_USED = (DETECTOR_COUNT > DET_FIELDS) ? DET_FIELDS :
                            ((DETECTOR_COUNT < 1) ? 1 : DETECTOR_COUNT);

  logic                     det_fault_r;
  logic                     det_fault_nxt;
  logic signed [TEMP_W-1:0] hi;
  logic signed [TEMP_W-1:0] lo;
  logic signed [EXT_W-1:0]  hi_x;
  logic signed [EXT_W-1:0]  lo_x;
  logic signed [EXT_W-1:0]  spread;
  logic signed [EXT_W-1:0]  h;

  always_comb begin
    hi = NONE_MAX;
    lo = NONE_MIN;
    for (int i = 0; i < DET_USED; i++) begin
      if (det_temp[i] != INVALID_TEMP) begin
        if (det_temp[i] > hi) hi = det_temp[i];
        if (det_temp[i] < lo) lo = det_temp[i];
      end
    end
  end

  assign hi_x   = EXT_W'(hi);
  assign lo_x   = EXT_W'(lo);
  assign spread = hi_x - lo_x;
  assign h      = det_fault_r ? HYST : '0;

  always_comb begin
    priority if (hi_x > RANGE_HI - h || lo_x < RANGE_LO + h || spread > MAX_SPREAD - h) begin
      det_fault_nxt = 1'b1;
    end else if (hi_x >= lo_x) begin
      det_fault_nxt = 1'b0;
    end else begin
      det_fault_nxt = det_fault_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_fault_r <= 1'b0;
    end else if (adv) begin
      det_fault_r <= det_fault_nxt;
    end
  end

  assign det_fault = det_fault_nxt;
  assign det_max   = hi;
  assign det_min   = lo;

endmodule

// ----- hw/rtl/tfm_laser_levels.sv -----
module tfm_laser_levels (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic signed [tfm_pkg::TEMP_W-1:0] laser_temp,
  input  logic                              warmed_up,
  input  tfm_pkg::tfm_thresh_t              thresh,
  output tfm_pkg::tfm_levels_t              levels
);
  import tfm_pkg::*;

  tfm_levels_t levels_r;
  tfm_levels_t levels_nxt;

  always_comb begin
    levels_nxt = levels_r;
    if (warmed_up) begin
      priority if (laser_temp > thresh.l3_set) begin
        levels_nxt.level3  = 1'b1;
        levels_nxt.inhibit = 1'b1;
      end else if (laser_temp <= thresh.l3_heal) begin
        levels_nxt.level3  = 1'b0;
        levels_nxt.inhibit = 1'b0;
      end else begin
        levels_nxt.level3  = levels_r.level3;
        levels_nxt.inhibit = levels_r.inhibit;
      end
      priority if (laser_temp > thresh.l2_set) begin
        levels_nxt.level2 = 1'b1;
      end else if (laser_temp <= thresh.l2_heal) begin
        levels_nxt.level2 = 1'b0;
      end else begin
        levels_nxt.level2 = levels_r.level2;
      end
      priority if (laser_temp > thresh.l1_set) begin
        levels_nxt.level1 = 1'b1;
      end else if (laser_temp <= thresh.l1_heal) begin
        levels_nxt.level1 = 1'b0;
      end else begin
        levels_nxt.level1 = levels_r.level1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= '0;
    end else if (adv) begin
      levels_r <= levels_nxt;
    end
  end

  assign levels = levels_nxt;

endmodule

// ----- hw/rtl/temperature_fault_monitor_core.sv -----
// An accepted transaction goes to the input register, then to the result register (out_tvalid).
// Throughput: one transaction per cycle unless out_tready stalls; evaluation is a single pass
// of comparators between the input and result registers, both of which hold while stalled.
// Reset (rst_n low, synchronous): all fault and overheat flags cleared, both stages
// emptied, thresholds back to their defaults.
module temperature_fault_monitor_core #(
  parameter int DETECTOR_COUNT = tfm_pkg::DET_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // laser_temp, det_temp_a, det_temp_b, det_temp_c, det_temp_d
  input  logic [tfm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // warmed_up
  input  logic [tfm_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // det_max, det_min
  output logic [tfm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // det_fault, overheat_one, overheat_two, overheat_three, high_inhibit
  output logic [tfm_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input  logic                             cfg_we,
  input  logic [tfm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tfm_pkg::TEMP_W-1:0]       cfg_wdata
);
  import tfm_pkg::*;

  logic                     s1_valid_r;
  logic [IN_TDATA_W-1:0]    s1_data_r;
  logic [IN_TUSER_W-1:0]    s1_user_r;
  logic                     out_valid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;
  logic [OUT_TUSER_W-1:0]   out_user_r;

  logic                     adv;
  logic                     in_fire;
  logic signed [TEMP_W-1:0] laser_temp;
  logic signed [TEMP_W-1:0] det_temp [DET_FIELDS];
  logic                     det_fault;
  logic signed [TEMP_W-1:0] det_max;
  logic signed [TEMP_W-1:0] det_min;
  tfm_thresh_t              thresh;
  tfm_levels_t              levels;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_tdata;
      s1_user_r <= in_tuser;
    end
  end

  assign laser_temp = s1_data_r[TEMP_W-1:0];
  for (genvar g = 0; g < DET_FIELDS; g++) begin : g_det
    assign det_temp[g] = s1_data_r[TEMP_W*(g+2)-1 -: TEMP_W];
  end

  tfm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .thresh    (thresh)
  );

  tfm_det_eval #(
    .DETECTOR_COUNT (DETECTOR_COUNT)
  ) u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .det_temp  (det_temp),
    .det_fault (det_fault),
    .det_max   (det_max),
    .det_min   (det_min)
  );

  tfm_laser_levels u_laser (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .laser_temp (laser_temp),
    .warmed_up  (s1_user_r[0]),
    .thresh     (thresh),
    .levels     (levels)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {det_min, det_max};
      out_user_r <= {levels.inhibit, levels.level3, levels.level2, levels.level1, det_fault};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- hw/rtl/tfm_checker.sv -----
module tfm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tfm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [tfm_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import tfm_pkg::*;

  logic signed [TEMP_W-1:0] mx;
  logic signed [TEMP_W-1:0] mn;

  assign mx = out_tdata[TEMP_W-1:0];
  assign mn = out_tdata[2*TEMP_W-1:TEMP_W];

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_accept_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> ##2 out_tvalid)
    else $error("accepted transaction did not reach the result register");

  a_inhibit_follows_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[4] == out_tuser[3]))
    else $error("inhibit differs from top overheat level");

  a_no_valid_markers: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (mx < mn)) |-> (mx == NONE_MAX && mn == NONE_MIN))
    else $error("max below min without the no-reading markers");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind temperature_fault_monitor_core tfm_checker u_tfm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- verif/temperature_fault_monitor_core_test.sv -----
`timescale 1ns / 1ps
module temperature_fault_monitor_core_test;
  import tfm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic signed [TEMP_W-1:0] NO_READING = -16'sd10000;
  localparam int WINDOW_LO = -400;
  localparam int WINDOW_HI = 1200;
  localparam int SPREAD_MAX = 50;
  localparam int NARROWING = 20;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int CHUNK_ITEMS = 155;

  typedef struct {
    bit fault;
    bit lvl1;
    bit lvl2;
    bit lvl3;
    bit inhibit;
    int hottest;
    int coldest;
  } monitor_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  wire in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;  // laser_temp, det_temp_a..det_temp_d
  logic [IN_TUSER_W-1:0] in_tuser = '0;  // warmed_up
  wire out_tvalid;
  logic out_tready = 1'b0;
  wire [OUT_TDATA_W-1:0] out_tdata;      // det_max, det_min
  wire [OUT_TUSER_W-1:0] out_tuser;      // det_fault, overheat_one/two/three, high_inhibit
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TEMP_W-1:0] cfg_wdata = '0;

  temperature_fault_monitor_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic signed [TEMP_W-1:0] thresh [6] = '{L3_SET_RST, L3_HEAL_RST, L2_SET_RST,
                                           L2_HEAL_RST, L1_SET_RST, L1_HEAL_RST};
  bit det_alarm = 1'b0;
  bit lvl1_on = 1'b0;
  bit lvl2_on = 1'b0;
  bit lvl3_on = 1'b0;
  bit inhibit_on = 1'b0;

  monitor_status_t pending_status [$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int stall_cycles = 0;
  int threshold_set_no = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic monitor_status_t predict_status(
      input logic signed [TEMP_W-1:0] laser, a, b, c, d, input bit warm);
    logic signed [TEMP_W-1:0] det [4];
    int hi;
    int lo;
    int hyst;
    monitor_status_t s;
    det = '{a, b, c, d};
    hi = WINDOW_LO - 1;
    lo = WINDOW_HI + 1;
    foreach (det[k]) begin
      if (det[k] != NO_READING) begin
        if (int'(det[k]) > hi) hi = int'(det[k]);
        if (int'(det[k]) < lo) lo = int'(det[k]);
      end
    end
    hyst = det_alarm ? NARROWING : 0;
    if (hi > WINDOW_HI - hyst || lo < WINDOW_LO + hyst || hi - lo > SPREAD_MAX - hyst)
      det_alarm = 1'b1;
    else if (hi >= lo)
      det_alarm = 1'b0;
    if (warm) begin
      if (laser > thresh[CFG_L3_SET]) begin
        lvl3_on = 1'b1;
        inhibit_on = 1'b1;
      end else if (laser <= thresh[CFG_L3_HEAL]) begin
        lvl3_on = 1'b0;
        inhibit_on = 1'b0;
      end
      if (laser > thresh[CFG_L2_SET]) lvl2_on = 1'b1;
      else if (laser <= thresh[CFG_L2_HEAL]) lvl2_on = 1'b0;
      if (laser > thresh[CFG_L1_SET]) lvl1_on = 1'b1;
      else if (laser <= thresh[CFG_L1_HEAL]) lvl1_on = 1'b0;
    end
    s.fault = det_alarm;
    s.lvl1 = lvl1_on;
    s.lvl2 = lvl2_on;
    s.lvl3 = lvl3_on;
    s.inhibit = inhibit_on;
    s.hottest = hi;
    s.coldest = lo;
    return s;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  task automatic send_sample(input logic signed [TEMP_W-1:0] laser, a, b, c, d,
                             input bit warm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {d, c, b, a, laser};
    in_tuser <= warm;
    do @(negedge clk); while (in_tready !== 1'b1);
    pending_status.push_back(predict_status(laser, a, b, c, d, warm));
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [CFG_IDX_W-1:0] idx,
                               input logic signed [TEMP_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= CFG_L1_HEAL) thresh[idx] = val;
  endtask

  task automatic test_detector_window();
    send_sample(0, 200, 210, 220, 230, 1'b0);
    send_sample(0, 1200, 1190, 1180, 1170, 1'b0);
    send_sample(0, 1201, 1190, 1180, 1160, 1'b0);
    send_sample(0, NO_READING, NO_READING, NO_READING, NO_READING, 1'b0);
    send_sample(0, 1181, 1170, 1160, 1151, 1'b0);
    send_sample(0, 1180, 1170, 1160, 1150, 1'b0);
    send_sample(0, -401, -390, -380, -370, 1'b0);
    send_sample(0, -380, -370, -360, -351, 1'b0);
    send_sample(0, 0, 51, NO_READING, NO_READING, 1'b0);
    send_sample(0, 0, 30, NO_READING, NO_READING, 1'b0);
    send_sample(0, NO_READING, 50, NO_READING, 0, 1'b0);
    send_sample(0, -32768, 32767, NO_READING, NO_READING, 1'b0);
    send_sample(0, NO_READING, NO_READING, NO_READING, 500, 1'b0);
  endtask

  task automatic test_overheat_levels();
    send_sample(801, 300, 310, 320, 330, 1'b1);
    send_sample(901, 300, 310, 320, 330, 1'b1);
    send_sample(1001, 300, 310, 320, 330, 1'b1);
    send_sample(32767, 300, 310, 320, 330, 1'b0);
    send_sample(-32768, 300, 310, 320, 330, 1'b0);
    send_sample(960, 300, 310, 320, 330, 1'b1);
    send_sample(950, 300, 310, 320, 330, 1'b1);
    send_sample(850, 300, 310, 320, 330, 1'b1);
    send_sample(750, 300, 310, 320, 330, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    wait_for_results();
    // heal above set: the set test wins
    set_threshold(CFG_L3_SET, -32768);
    set_threshold(CFG_L3_HEAL, 32767);
    set_threshold(CFG_L2_SET, -32768);
    set_threshold(CFG_L2_HEAL, 32767);
    set_threshold(CFG_L1_SET, -32768);
    set_threshold(CFG_L1_HEAL, 32767);
    send_sample(-32767, 300, 310, 320, 330, 1'b1);
    send_sample(-32768, 300, 310, 320, 330, 1'b1);
    send_sample(-32767, 300, 310, 320, 330, 1'b1);
    wait_for_results();
    set_threshold(CFG_L3_SET, 32767);
    set_threshold(CFG_L3_HEAL, -32768);
    set_threshold(CFG_L2_SET, 32767);
    set_threshold(CFG_L2_HEAL, -32768);
    set_threshold(CFG_L1_SET, 32767);
    set_threshold(CFG_L1_HEAL, -32768);
    send_sample(32767, 300, 310, 320, 330, 1'b1);
    send_sample(-32768, 300, 310, 320, 330, 1'b1);
    wait_for_results();
    // writes to unmapped indexes must not land anywhere
    set_threshold(CFG_SPARE_LO, -32768);
    set_threshold(CFG_SPARE_HI, -32768);
    send_sample(-32767, 300, 310, 320, 330, 1'b1);
  endtask

  task automatic test_backpressure();
    wait_for_results();
    send_idle_pct <= 0;
    hold_len <= HOLD_OFF_CYCLES;
    repeat (30)
      send_sample(TEMP_W'($urandom), TEMP_W'(400 + $urandom_range(0, 60)),
                  TEMP_W'(400 + $urandom_range(0, 60)), NO_READING,
                  TEMP_W'(400 + $urandom_range(0, 60)), $urandom_range(1) != 0);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
    int done_items;
    int chunk;
    int base;
    int r;
    logic signed [TEMP_W-1:0] s1, h1, s2, h2, s3, h3, laser;
    logic signed [TEMP_W-1:0] reading [4];
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
    done_items = 0;
    while (done_items < items) begin
      chunk = (items - done_items < CHUNK_ITEMS) ? items - done_items : CHUNK_ITEMS;
      wait_for_results();
      case (threshold_set_no % 3)
        0: begin
          s1 = TEMP_W'(int'($urandom_range(0, 1400)) - 200);
          h1 = TEMP_W'(int'(s1) - int'($urandom_range(0, 100)));
          s2 = TEMP_W'(int'(s1) + int'($urandom_range(0, 150)));
          h2 = TEMP_W'(int'(s2) - int'($urandom_range(0, 100)));
          s3 = TEMP_W'(int'(s2) + int'($urandom_range(0, 150)));
          h3 = TEMP_W'(int'(s3) - int'($urandom_range(0, 100)));
        end
        1: begin
          s1 = TEMP_W'(int'($urandom_range(0, 2200)) - 600);
          h1 = TEMP_W'(int'($urandom_range(0, 2200)) - 600);
          s2 = TEMP_W'(int'($urandom_range(0, 2200)) - 600);
          h2 = TEMP_W'(int'($urandom_range(0, 2200)) - 600);
          s3 = TEMP_W'(int'($urandom_range(0, 2200)) - 600);
          h3 = TEMP_W'(int'($urandom_range(0, 2200)) - 600);
        end
        default: begin
          s1 = TEMP_W'($urandom_range(1) ? 32767 : -32768);
          h1 = TEMP_W'($urandom_range(1) ? 32767 : -32768);
          s2 = TEMP_W'($urandom_range(1) ? 32767 : -32768);
          h2 = TEMP_W'($urandom_range(1) ? 32767 : -32768);
          s3 = TEMP_W'($urandom_range(1) ? 32767 : -32768);
          h3 = TEMP_W'($urandom_range(1) ? 32767 : -32768);
        end
      endcase
      threshold_set_no++;
      set_threshold(CFG_L1_SET, s1);
      set_threshold(CFG_L1_HEAL, h1);
      set_threshold(CFG_L2_SET, s2);
      set_threshold(CFG_L2_HEAL, h2);
      set_threshold(CFG_L3_SET, s3);
      set_threshold(CFG_L3_HEAL, h3);
      if ($urandom_range(1)) set_threshold($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                                           TEMP_W'($urandom));
      repeat (chunk) begin
        base = int'($urandom_range(0, 1680)) - 450;
        foreach (reading[k]) begin
          r = $urandom_range(99);
          if (r < 12) reading[k] = NO_READING;
          else if (r < 20) reading[k] = TEMP_W'($urandom);
          else reading[k] = TEMP_W'(base + int'($urandom_range(0, 56)));
        end
        if ($urandom_range(19) == 0) reading = '{NO_READING, NO_READING, NO_READING, NO_READING};
        r = $urandom_range(99);
        if (r < 60)
          laser = TEMP_W'(int'(thresh[$urandom_range(0, 5)]) + int'($urandom_range(0, 6)) - 3);
        else if (r < 85) laser = TEMP_W'(int'($urandom_range(0, 2000)) - 500);
        else laser = TEMP_W'($urandom);
        send_sample(laser, reading[0], reading[1], reading[2], reading[3],
                    $urandom_range(99) < 85);
      end
      done_items += chunk;
    end
  endtask

  always @(posedge clk) begin
    if (hold_len != 0) begin
      out_tready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(negedge clk) begin
    monitor_status_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                 $time, out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        check_field("det_fault", want.fault, out_tuser[0]);
        check_field("overheat_one", want.lvl1, out_tuser[1]);
        check_field("overheat_two", want.lvl2, out_tuser[2]);
        check_field("overheat_three", want.lvl3, out_tuser[3]);
        check_field("high_inhibit", want.inhibit, out_tuser[4]);
        check_field("det_max", want.hottest, $signed(out_tdata[TEMP_W-1:0]));
        check_field("det_min", want.coldest, $signed(out_tdata[2*TEMP_W-1:TEMP_W]));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_detector_window();
    test_overheat_levels();
    test_threshold_extremes();
    test_backpressure();
    test_random_traffic(465, 25, 54);
    test_random_traffic(465, 54, 25);
    test_random_traffic(465, 0, 0);
    wait_for_results();
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
